[rtl/cmt_pkg.sv]
// shared types, constants and codes of the client mac table
`default_nettype none
package cmt_pkg;

    localparam int ENTRIES      = 64;
    localparam int IDX_W        = $clog2(ENTRIES);
    localparam int ADDR_W       = $clog2(ENTRIES + 1);
    localparam int CNT_W        = 7;
    localparam int MAC_W        = 48;
    localparam int IP_W         = 32;
    localparam int TIME_BITS    = 32;
    localparam int CFG_W        = 32;
    localparam int SWEEP_PERIOD = 30 * 1000;
    localparam logic [CFG_W-1:0] IDLE_RESET = CFG_W'(2 * SWEEP_PERIOD);

    // command codes
    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_LOOKUP = 3'd1;
    localparam logic [2:0] CMD_SET    = 3'd2;
    localparam logic [2:0] CMD_TOUCH  = 3'd3;
    localparam logic [2:0] CMD_SWEEP  = 3'd4;
    localparam logic [2:0] CMD_CLEAR  = 3'd5;

    // outcome codes
    localparam logic [1:0] OUT_FOUND     = 2'd0;
    localparam logic [1:0] OUT_CREATED   = 2'd1;
    localparam logic [1:0] OUT_NOT_FOUND = 2'd2;
    localparam logic [1:0] OUT_FULL      = 2'd3;

    typedef enum logic [2:0] {
        OP_ADD, OP_LOOKUP, OP_SET, OP_TOUCH, OP_SWEEP, OP_CLEAR, OP_NONE
    } t_op;

    typedef enum logic [1:0] {
        B_IDLE, B_SCAN, B_FINISH
    } t_bstate;

    typedef struct packed {
        logic [2:0]           command;
        logic [MAC_W-1:0]     mac_address;
        logic [IP_W-1:0]      ipv4_address;
        logic                 new_status;
        logic [TIME_BITS-1:0] now;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       outcome;
        logic             status;
        logic [IP_W-1:0]  ipv4_out;
        logic [CNT_W-1:0] removed_count;
        logic [CNT_W-1:0] entries_used;
    } t_out_item;

    typedef struct packed {
        t_op      op;
        t_in_item item;
    } t_job;

    typedef struct packed {
        logic [MAC_W-1:0]     mac;
        logic [IP_W-1:0]      ipv4;
        logic                 status;
        logic [TIME_BITS-1:0] last_active;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage
`default_nettype wire

[rtl/cmt_ram.sv]
// generic single write, single read ram with registered read data
`default_nettype none
module cmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/cmt_front.sv]
// front end: accepts commands, classifies them and queues them for the back end
`default_nettype none
module cmt_front import cmt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_item i_in,
    output logic          o_full,
    output logic          o_job_valid,
    output t_job          o_job,
    input  wire logic     i_job_take
);
    t_job       r_q [2];
    logic       r_wp, r_rp, n_wp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    t_op        w_op;
    logic       w_wr, w_rd;

    // classify the command
    always_comb begin
        case (i_in.command)
            CMD_ADD:    w_op = OP_ADD;
            CMD_LOOKUP: w_op = OP_LOOKUP;
            CMD_SET:    w_op = OP_SET;
            CMD_TOUCH:  w_op = OP_TOUCH;
            CMD_SWEEP:  w_op = OP_SWEEP;
            CMD_CLEAR:  w_op = OP_CLEAR;
            default:    w_op = OP_NONE;
        endcase
    end

    // queue pointers
    always_comb begin
        o_full      = (r_cnt == 2'd2);
        o_job_valid = (r_cnt != 2'd0);
        o_job       = r_q[r_rp];
        w_wr        = i_push && !o_full;
        w_rd        = i_job_take && o_job_valid;
        n_wp        = r_wp ^ w_wr;
        n_rp        = r_rp ^ w_rd;
        n_cnt       = r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= '{op: w_op, item: i_in};
        end
    end
endmodule
`default_nettype wire

[rtl/cmt_back.sv]
// back end: scans the entry memory, applies each command and queues results
`default_nettype none
module cmt_back import cmt_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    input  wire logic             i_job_valid,
    input  wire t_job             i_job,
    output logic                  o_job_take,
    output logic                  o_empty,
    output t_out_item             o_out,
    input  wire logic             i_pop
);
    t_bstate           r_state, n_state;
    t_job              r_job;
    logic [ADDR_W-1:0] r_addr;
    logic              r_pend;
    logic [IDX_W-1:0]  r_idx;
    logic              r_hit, n_hit;
    t_entry            r_hit_data;
    logic              r_free_ok, n_free_ok;
    logic [IDX_W-1:0]  r_free_idx, n_free_idx;
    logic [CNT_W-1:0]  r_removed, n_removed;
    logic [CNT_W-1:0]  r_used, n_used;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [CFG_W-1:0]  r_timeout;

    t_out_item         r_oq [2];
    logic              r_owp, r_orp;
    logic [1:0]        r_ocnt;
    logic              w_opush, w_opop;
    t_out_item         w_res;

    logic              w_issue, w_scan_done, w_match;
    logic [ENTRY_W-1:0] w_rdata;
    t_entry            w_rd;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    t_entry            w_wdata;
    logic [TIME_BITS-1:0] w_idle;

    assign w_rd = t_entry'(w_rdata);

    cmt_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (ENTRY_W'(w_wdata)),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // scan status
    always_comb begin
        w_issue     = (r_addr < ADDR_W'(ENTRIES));
        w_match     = r_pend && r_valid[r_idx] && (w_rd.mac == r_job.item.mac_address)
                      && (r_job.op != OP_SWEEP);
        w_scan_done = w_match || (!w_issue && !r_pend);
        w_idle      = r_job.item.now - w_rd.last_active;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_job_valid && r_ocnt != 2'd2) begin
                    if (i_job.op == OP_CLEAR || i_job.op == OP_NONE) begin
                        n_state = B_FINISH;
                    end else begin
                        n_state = B_SCAN;
                    end
                end
            end
            B_SCAN: begin
                if (w_scan_done) begin
                    n_state = B_FINISH;
                end
            end
            B_FINISH: n_state = B_IDLE;
            default:  n_state = B_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        o_job_take = (r_state == B_IDLE) && i_job_valid && (r_ocnt != 2'd2);
        n_hit      = r_hit;
        n_free_ok  = r_free_ok;
        n_free_idx = r_free_idx;
        n_removed  = r_removed;
        n_used     = r_used;
        n_valid    = r_valid;
        w_we       = 1'b0;
        w_waddr    = r_free_idx;
        w_wdata    = r_hit_data;
        w_opush    = 1'b0;
        w_res      = '0;
        w_res.outcome = OUT_NOT_FOUND;
        case (r_state)
            B_IDLE: begin
                n_hit     = 1'b0;
                n_free_ok = 1'b0;
                n_removed = '0;
            end
            B_SCAN: begin
                if (r_pend) begin
                    if (r_job.op == OP_SWEEP) begin
                        if (r_valid[r_idx] && (w_idle > r_timeout)) begin
                            n_valid[r_idx] = 1'b0;
                            n_removed      = r_removed + 1'b1;
                        end
                    end else if (w_match) begin
                        n_hit      = 1'b1;
                        n_free_idx = r_idx;
                    end else if (!r_valid[r_idx] && !r_free_ok) begin
                        n_free_ok  = 1'b1;
                        n_free_idx = r_idx;
                    end
                end
            end
            B_FINISH: begin
                w_opush = 1'b1;
                case (r_job.op)
                    OP_ADD: begin
                        if (r_hit) begin
                            w_res.outcome  = OUT_FOUND;
                            w_res.status   = r_hit_data.status;
                            w_res.ipv4_out = r_hit_data.ipv4;
                        end else if (r_free_ok) begin
                            w_we                = 1'b1;
                            w_wdata.mac         = r_job.item.mac_address;
                            w_wdata.ipv4        = r_job.item.ipv4_address;
                            w_wdata.status      = 1'b0;
                            w_wdata.last_active = r_job.item.now;
                            n_valid[r_free_idx] = 1'b1;
                            n_used              = r_used + 1'b1;
                            w_res.outcome       = OUT_CREATED;
                            w_res.ipv4_out      = r_job.item.ipv4_address;
                        end else begin
                            w_res.outcome = OUT_FULL;
                        end
                    end
                    OP_LOOKUP, OP_SET, OP_TOUCH: begin
                        if (r_hit) begin
                            w_we           = (r_job.op != OP_LOOKUP);
                            if (r_job.op == OP_SET) begin
                                w_wdata.status = r_job.item.new_status;
                            end
                            if (r_job.op == OP_TOUCH) begin
                                w_wdata.last_active = r_job.item.now;
                            end
                            w_res.outcome  = OUT_FOUND;
                            w_res.status   = w_wdata.status;
                            w_res.ipv4_out = r_hit_data.ipv4;
                        end
                    end
                    OP_SWEEP: begin
                        w_res.outcome       = OUT_FOUND;
                        w_res.removed_count = r_removed;
                        n_used              = r_used - r_removed;
                    end
                    OP_CLEAR: begin
                        w_res.outcome       = OUT_FOUND;
                        w_res.removed_count = r_used;
                        n_valid             = '0;
                        n_used              = '0;
                    end
                    default: w_res.outcome = OUT_NOT_FOUND;
                endcase
                w_res.entries_used = n_used;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_valid   <= '0;
            r_used    <= '0;
            r_timeout <= IDLE_RESET;
            r_pend    <= 1'b0;
            r_addr    <= '0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_removed <= '0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_used    <= n_used;
            r_hit     <= n_hit;
            r_free_ok <= n_free_ok;
            r_removed <= n_removed;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (r_state == B_SCAN && !w_scan_done) begin
                r_pend <= w_issue;
                if (w_issue) begin
                    r_addr <= r_addr + 1'b1;
                end
            end else begin
                r_pend <= 1'b0;
                r_addr <= '0;
            end
        end
    end

    // scan payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= r_addr[IDX_W-1:0];
        r_free_idx <= n_free_idx;
        if (o_job_take) begin
            r_job <= i_job;
        end
        if (w_match) begin
            r_hit_data <= w_rd;
        end
    end

    // result queue
    always_comb begin
        o_empty = (r_ocnt == 2'd0);
        o_out   = r_oq[r_orp];
        w_opop  = i_pop && !o_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            r_owp  <= r_owp ^ w_opush;
            r_orp  <= r_orp ^ w_opop;
            r_ocnt <= r_ocnt + {1'b0, w_opush} - {1'b0, w_opop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_opush) begin
            r_oq[r_owp] <= w_res;
        end
    end
endmodule
`default_nettype wire

[rtl/client_mac_table_with_aging.sv]
// top level of the client mac table with aging
`default_nettype none
// Client table of 64 entries keyed by 48-bit MAC, each with an IPv4 address,
// a status and a last-active time. Commands enter a two-deep queue (push/full)
// and results leave through a two-deep queue (empty/pop). Add, lookup, set
// status, touch and age sweep walk the entry memory one entry per cycle (a hit
// stops the walk early); clear and unused commands skip the walk. The idle
// timeout register resets to 60000 and is to be written through
// i_cfg_we/i_cfg_wdata only while the block is idle; the block itself does not
// enforce this. Valid bits reset at once, so no clearing pass is needed.
module client_mac_table_with_aging import cmt_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire t_in_item         i_in,
    output logic                  empty,
    input  wire logic             pop,
    output t_out_item             o_out,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);
    logic w_job_valid, w_job_take;
    t_job w_job;

    cmt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in        (i_in),
        .o_full      (full),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_take  (w_job_take)
    );

    cmt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_take  (w_job_take),
        .o_empty     (empty),
        .o_out       (o_out),
        .i_pop       (pop)
    );

`ifndef ASSERT_OFF
    // result queue is empty right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> empty) else $error("result queue not empty after reset");

    // count never exceeds the table size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out.entries_used <= CNT_W'(ENTRIES)))
        else $error("entries_used beyond table size");

    // only sweep and clear report removals, and they report outcome zero
    a_removed_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.removed_count != '0) |-> (o_out.outcome == OUT_FOUND))
        else $error("removal reported with wrong outcome");

    // a created entry is offline
    a_created_offline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.outcome == OUT_CREATED) |-> !o_out.status)
        else $error("created entry not offline");
`endif
endmodule
`default_nettype wire
